/* design/dual_port_uart_fifo_router_assert.svh */
// Assertion macros for the dual-port serial FIFO router checks
`ifndef DUAL_PORT_UART_FIFO_ROUTER_ASSERT_SVH
`define DUAL_PORT_UART_FIFO_ROUTER_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define DPUFR_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("dpufr check failed");

// Check that a condition implies another in the next cycle
`define DPUFR_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("dpufr check failed");

`endif

/* design/dpufr_pkg.sv */
// Shared types and constants for the dual-port serial FIFO router
package dpufr_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W     = 2 + PTR_W;
  localparam int MEM_DEPTH  = 4 << PTR_W;

  typedef enum logic [2:0] {
    CMD_RX0  = 3'd0,
    CMD_RX1  = 3'd1,
    CMD_SEND = 3'd2,
    CMD_RECV = 3'd3,
    CMD_TX0  = 3'd4,
    CMD_TX1  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DROP  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_port;
    status_t    status;
    logic       tx_pending_0;
    logic       tx_pending_1;
  } rsp_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

endpackage

/* design/dual_port_uart_fifo_router.sv */
// Top level of the dual-port serial FIFO router
// Push and status-only words give a registered result in the cycle after
// acceptance; a pop's result follows the registered memory read and ST_READ.
// Pushes are taken one word per cycle unless rsp_ready holds results back;
// after a pop no word is taken until ST_READ is over. Reset clears pointers,
// counts and flags at once; FIFO contents are not cleared and need no clearing pass.
module dual_port_uart_fifo_router (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  dpufr_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output dpufr_pkg::rsp_t  rsp
);

  dpufr_pkg::mem_req_t mem_req;
  logic [7:0]          rd_data;

  dpufr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  dpufr_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

/* design/dpufr_mem.sv */
// Byte memory holding all four FIFO stores, one access per cycle, registered read
module dpufr_mem (
  input  logic                 clk,
  input  dpufr_pkg::mem_req_t  mem_req,
  output logic [7:0]           rd_data
);

  logic [7:0] mem [dpufr_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.addr] <= mem_req.wdata;
    end
    if (mem_req.rd_en) begin
      rd_data <= mem[mem_req.addr];
    end
  end

endmodule

/* design/dpufr_ctrl.sv */
// FIFO pointers, counts, routing decisions and result register
module dpufr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  dpufr_pkg::req_t      req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output dpufr_pkg::rsp_t      rsp,
  output dpufr_pkg::mem_req_t  mem_req,
  input  logic [7:0]           rd_data
);

  localparam int PW = dpufr_pkg::PTR_W;
  localparam int CW = dpufr_pkg::CNT_W;

  dpufr_pkg::state_t  state, state_next;
  logic [PW-1:0]      rd_ptr [4];
  logic [PW-1:0]      wr_ptr [4];
  logic [CW-1:0]      count  [4];
  logic               reply_port, reply_next;
  logic [1:0]         tx_pend, pend_next;
  logic [1:0]         q;
  logic               push, pop, accept, res_port;
  dpufr_pkg::status_t res_status;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
    ptr_inc = (ptr == PW'(dpufr_pkg::FIFO_DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  always_comb begin
    q          = 2'd0;
    push       = 1'b0;
    pop        = 1'b0;
    reply_next = reply_port;
    pend_next  = tx_pend;
    res_port   = 1'b0;
    res_status = dpufr_pkg::STAT_OK;
    case (req.command)
      dpufr_pkg::CMD_RX0, dpufr_pkg::CMD_RX1: begin
        q        = {1'b0, req.command[0]};
        res_port = req.command[0];
        if (count[q] == CW'(dpufr_pkg::FIFO_DEPTH)) begin
          res_status = dpufr_pkg::STAT_DROP;
        end else begin
          push = 1'b1;
        end
      end
      dpufr_pkg::CMD_SEND: begin
        q        = {1'b1, reply_port};
        res_port = reply_port;
        if (count[q] == CW'(dpufr_pkg::FIFO_DEPTH)) begin
          res_status = dpufr_pkg::STAT_FULL;
        end else begin
          push                  = 1'b1;
          pend_next[reply_port] = 1'b1;
        end
      end
      dpufr_pkg::CMD_RECV: begin
        if (count[0] != '0) begin
          q          = 2'd0;
          pop        = 1'b1;
          reply_next = 1'b0;
        end else if (count[1] != '0) begin
          q          = 2'd1;
          pop        = 1'b1;
          reply_next = 1'b1;
        end else begin
          res_status = dpufr_pkg::STAT_EMPTY;
        end
        res_port = reply_next;
      end
      dpufr_pkg::CMD_TX0, dpufr_pkg::CMD_TX1: begin
        q        = {1'b1, req.command[0]};
        res_port = req.command[0];
        if (count[q] != '0) begin
          pop = 1'b1;
        end else begin
          res_status = dpufr_pkg::STAT_EMPTY;
        end
        if (count[q] <= CW'(1)) begin
          pend_next[req.command[0]] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    case (state)
      dpufr_pkg::ST_IDLE: begin
        req_ready = !rsp_valid || rsp_ready;
        if (req_valid && req_ready && pop) begin
          state_next = dpufr_pkg::ST_READ;
        end
      end
      dpufr_pkg::ST_READ: begin
        state_next = dpufr_pkg::ST_IDLE;
      end
      default: begin
        state_next = dpufr_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept        = req_valid && req_ready;
  assign mem_req.wr_en = accept && push;
  assign mem_req.rd_en = accept && pop;
  assign mem_req.addr  = {q, push ? wr_ptr[q] : rd_ptr[q]};
  assign mem_req.wdata = req.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dpufr_pkg::ST_IDLE;
      rsp_valid  <= 1'b0;
      reply_port <= 1'b0;
      tx_pend    <= 2'b00;
      for (int i = 0; i < 4; i++) begin
        rd_ptr[i] <= '0;
        wr_ptr[i] <= '0;
        count[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        reply_port <= reply_next;
        tx_pend    <= pend_next;
        rsp_valid  <= !pop;
        if (push) begin
          wr_ptr[q] <= ptr_inc(wr_ptr[q]);
          count[q]  <= count[q] + CW'(1);
        end
        if (pop) begin
          rd_ptr[q] <= ptr_inc(rd_ptr[q]);
          count[q]  <= count[q] - CW'(1);
        end
      end else if (state == dpufr_pkg::ST_READ) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // hold result payload; patch in the popped byte from the registered read data in ST_READ
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.out_byte     <= 8'd0;
      rsp.out_port     <= res_port;
      rsp.status       <= res_status;
      rsp.tx_pending_0 <= pend_next[0];
      rsp.tx_pending_1 <= pend_next[1];
    end else if (state == dpufr_pkg::ST_READ) begin
      rsp.out_byte <= rd_data;
    end
  end

endmodule

/* design/dpufr_checker.sv */
// Port-level checker for the dual-port serial FIFO router, with its bind
`include "dual_port_uart_fifo_router_assert.svh"

module dpufr_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input dpufr_pkg::req_t  req,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input dpufr_pkg::rsp_t  rsp
);

  `DPUFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `DPUFR_ASSERT_NOW(a_no_take_when_blocked, rsp_valid && !rsp_ready, !req_ready)
  `DPUFR_ASSERT_NOW(a_empty_zero_byte,
    rsp_valid && rsp.status == dpufr_pkg::STAT_EMPTY, rsp.out_byte == 8'd0)
  `DPUFR_ASSERT_NOW(a_reject_zero_byte,
    rsp_valid && (rsp.status == dpufr_pkg::STAT_DROP || rsp.status == dpufr_pkg::STAT_FULL),
    rsp.out_byte == 8'd0)

endmodule

bind dual_port_uart_fifo_router dpufr_checker u_checker (.*);

/* verif/tb_top.sv */
// Self-checking testbench for the dual-port serial FIFO router, directed and random traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 10;
  localparam int Q_RX0 = 0;
  localparam int Q_RX1 = 1;
  localparam int Q_TX0 = 2;
  localparam int Q_TX1 = 3;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  dpufr_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  dpufr_pkg::rsp_t rsp;

  logic [7:0] fifo_mem [4][dpufr_pkg::FIFO_DEPTH];
  int fifo_rd [4];
  int fifo_wr [4];
  int fifo_cnt [4];
  logic host_port;
  logic [1:0] tx_pend;

  dpufr_pkg::rsp_t due_rsp [$];
  dpufr_pkg::rsp_t want;
  int mismatch_count = 0;
  bit calm = 1'b0;

  dual_port_uart_fifo_router dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic bit fifo_put(int q, logic [7:0] b);
    if (fifo_cnt[q] >= dpufr_pkg::FIFO_DEPTH) return 1'b0;
    fifo_mem[q][fifo_wr[q]] = b;
    fifo_wr[q] = (fifo_wr[q] + 1 >= dpufr_pkg::FIFO_DEPTH) ? 0 : fifo_wr[q] + 1;
    fifo_cnt[q]++;
    return 1'b1;
  endfunction

  function automatic bit fifo_take(int q, output logic [7:0] b);
    b = 8'h00;
    if (fifo_cnt[q] == 0) return 1'b0;
    b = fifo_mem[q][fifo_rd[q]];
    fifo_rd[q] = (fifo_rd[q] + 1 >= dpufr_pkg::FIFO_DEPTH) ? 0 : fifo_rd[q] + 1;
    fifo_cnt[q]--;
    return 1'b1;
  endfunction

  function automatic dpufr_pkg::rsp_t route_word(dpufr_pkg::req_t w);
    dpufr_pkg::rsp_t r;
    logic [7:0] b;
    int q;
    r = '0;
    r.status = dpufr_pkg::STAT_OK;
    b = 8'h00;
    case (w.command)
      dpufr_pkg::CMD_RX0, dpufr_pkg::CMD_RX1: begin
        r.out_port = (w.command == dpufr_pkg::CMD_RX1);
        if (!fifo_put(r.out_port ? Q_RX1 : Q_RX0, w.data_byte)) r.status = dpufr_pkg::STAT_DROP;
      end
      dpufr_pkg::CMD_SEND: begin
        r.out_port = host_port;
        q = host_port ? Q_TX1 : Q_TX0;
        if (fifo_put(q, w.data_byte)) tx_pend[host_port] = 1'b1;
        else r.status = dpufr_pkg::STAT_FULL;
      end
      dpufr_pkg::CMD_RECV: begin
        if (fifo_take(Q_RX0, b)) host_port = 1'b0;
        else if (fifo_take(Q_RX1, b)) host_port = 1'b1;
        else r.status = dpufr_pkg::STAT_EMPTY;
        r.out_port = host_port;
      end
      dpufr_pkg::CMD_TX0, dpufr_pkg::CMD_TX1: begin
        r.out_port = (w.command == dpufr_pkg::CMD_TX1);
        q = r.out_port ? Q_TX1 : Q_TX0;
        if (!fifo_take(q, b)) r.status = dpufr_pkg::STAT_EMPTY;
        if (fifo_cnt[q] == 0) tx_pend[r.out_port] = 1'b0;
      end
      default: ;
    endcase
    r.out_byte = b;
    r.tx_pending_0 = tx_pend[0];
    r.tx_pending_1 = tx_pend[1];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  task automatic hold_off(int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_word(dpufr_pkg::cmd_t c, logic [7:0] d);
    dpufr_pkg::req_t w;
    w.command = c;
    w.data_byte = d;
    if (!calm && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 14));
    req <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    due_rsp.push_back(route_word(w));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (due_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic dpufr_pkg::cmd_t pick_cmd(int mode);
    int push_pct;
    if ($urandom_range(0, 99) == 0)
      return dpufr_pkg::cmd_t'($urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6);
    push_pct = (mode == MODE_FILL) ? 90 : (mode == MODE_DRAIN) ? 15 : 50;
    if ($urandom_range(0, 99) < push_pct) begin
      case ($urandom_range(0, 2))
        0: return dpufr_pkg::CMD_RX0;
        1: return dpufr_pkg::CMD_RX1;
        default: return dpufr_pkg::CMD_SEND;
      endcase
    end
    case ($urandom_range(0, 2))
      0: return dpufr_pkg::CMD_RECV;
      1: return dpufr_pkg::CMD_TX0;
      default: return dpufr_pkg::CMD_TX1;
    endcase
  endfunction

  task automatic test_directed_cases();
    send_word(dpufr_pkg::CMD_RECV, 8'h00);
    send_word(dpufr_pkg::CMD_TX0, 8'hFF);
    send_word(dpufr_pkg::CMD_TX1, 8'h00);
    send_word(dpufr_pkg::cmd_t'(CMD_SPARE_6), 8'hFF);
    send_word(dpufr_pkg::cmd_t'(CMD_SPARE_7), 8'h00);
    send_word(dpufr_pkg::CMD_RX0, 8'h00);
    send_word(dpufr_pkg::CMD_RX1, 8'hFF);
    send_word(dpufr_pkg::CMD_RX1, 8'h5A);
    send_word(dpufr_pkg::CMD_RECV, 8'hFF);
    send_word(dpufr_pkg::CMD_RECV, 8'h00);
    send_word(dpufr_pkg::CMD_SEND, 8'hA5);
    send_word(dpufr_pkg::CMD_SEND, 8'h00);
    send_word(dpufr_pkg::CMD_TX1, 8'h00);
    send_word(dpufr_pkg::CMD_TX1, 8'hFF);
    send_word(dpufr_pkg::CMD_RECV, 8'h00);
    send_word(dpufr_pkg::CMD_RECV, 8'h00);
    send_word(dpufr_pkg::CMD_SEND, 8'hFF);
    send_word(dpufr_pkg::CMD_TX0, 8'h00);
    send_word(dpufr_pkg::CMD_TX1, 8'h00);
  endtask

  task automatic test_fifo_limits();
    repeat (dpufr_pkg::FIFO_DEPTH + 1)
      send_word(dpufr_pkg::CMD_RX0, 8'($urandom_range(0, 255)));
    repeat (dpufr_pkg::FIFO_DEPTH + 1)
      send_word(dpufr_pkg::CMD_RX1, 8'($urandom_range(0, 255)));
    repeat (2 * dpufr_pkg::FIFO_DEPTH + 1)
      send_word(dpufr_pkg::CMD_RECV, 8'($urandom_range(0, 255)));
    repeat (dpufr_pkg::FIFO_DEPTH + 1)
      send_word(dpufr_pkg::CMD_SEND, 8'($urandom_range(0, 255)));
    send_word(dpufr_pkg::CMD_RX0, 8'($urandom_range(0, 255)));
    send_word(dpufr_pkg::CMD_RECV, 8'($urandom_range(0, 255)));
    repeat (dpufr_pkg::FIFO_DEPTH + 1)
      send_word(dpufr_pkg::CMD_SEND, 8'($urandom_range(0, 255)));
    repeat (dpufr_pkg::FIFO_DEPTH + 2)
      send_word(dpufr_pkg::CMD_TX0, 8'($urandom_range(0, 255)));
    repeat (dpufr_pkg::FIFO_DEPTH + 2)
      send_word(dpufr_pkg::CMD_TX1, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_traffic(int total);
    int sent;
    int burst;
    int mode;
    bit paused;
    sent = 0;
    paused = 1'b0;
    while (sent < total) begin
      mode = $urandom_range(MODE_FILL, MODE_MIXED);
      burst = $urandom_range(20, 200);
      if (burst > total - sent) burst = total - sent;
      repeat (burst) begin
        send_word(pick_cmd(mode), 8'($urandom_range(0, 255)));
        sent++;
      end
      if (!paused && sent >= total / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_steady_tail(int total);
    calm = 1'b1;
    repeat (total) send_word(pick_cmd(MODE_MIXED), 8'($urandom_range(0, 255)));
  endtask

  initial begin : sink
    int span;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        span = $urandom_range(1, 14);
        repeat (span) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      span = calm ? 1 : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 8);
      repeat (span - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (due_rsp.size() == 0) begin
        report_mismatch("unexpected word", int'(rsp), 0);
      end else begin
        want = due_rsp.pop_front();
        if (rsp.out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(rsp.out_byte), int'(want.out_byte));
        if (rsp.out_port !== want.out_port)
          report_mismatch("out_port", int'(rsp.out_port), int'(want.out_port));
        if (rsp.status !== want.status)
          report_mismatch("status", int'(rsp.status), int'(want.status));
        if (rsp.tx_pending_0 !== want.tx_pending_0)
          report_mismatch("tx_pending_0", int'(rsp.tx_pending_0), int'(want.tx_pending_0));
        if (rsp.tx_pending_1 !== want.tx_pending_1)
          report_mismatch("tx_pending_1", int'(rsp.tx_pending_1), int'(want.tx_pending_1));
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("dual_port_uart_fifo_router regression: fail");
    $finish;
  end

  initial begin : run
    int guard;
    for (int q = 0; q < 4; q++) begin
      fifo_rd[q] = 0;
      fifo_wr[q] = 0;
      fifo_cnt[q] = 0;
    end
    host_port = 1'b0;
    tx_pend = 2'b00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_fifo_limits();
    wait_drained();
    test_random_traffic(1300);
    test_steady_tail(130);
    req_valid <= 1'b0;
    guard = 0;
    while (due_rsp.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (due_rsp.size() != 0) report_mismatch("words never delivered", due_rsp.size(), 0);
    if (mismatch_count == 0) begin
      $display("dual_port_uart_fifo_router regression: pass");
    end else begin
      $display("dual_port_uart_fifo_router regression: fail");
    end
    $finish;
  end
endmodule
